// ----- sv/cot_pkg.sv -----
package cot_pkg;

  // face codes and holder positions share the same 3-bit encoding
  typedef logic [2:0] face_t;
  typedef face_t [5:0] faces_t;

  localparam int unsigned NumPos = 6;

  localparam logic [2:0] POS_UP    = 3'd0;
  localparam logic [2:0] POS_RIGHT = 3'd1;
  localparam logic [2:0] POS_FRONT = 3'd2;
  localparam logic [2:0] POS_DOWN  = 3'd3;
  localparam logic [2:0] POS_LEFT  = 3'd4;
  localparam logic [2:0] POS_BACK  = 3'd5;

  // operation codes
  localparam logic OP_MOVE = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // move codes
  localparam logic [2:0] MOVE_NONE   = 3'd0;
  localparam logic [2:0] MOVE_TUMBLE = 3'd1;
  localparam logic [2:0] MOVE_CW     = 3'd2;
  localparam logic [2:0] MOVE_ACW    = 3'd3;
  localparam logic [2:0] MOVE_HALF   = 3'd4;

  // orientation after reset: U R F D L B
  localparam faces_t RESET_FACES = {3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};

  // quarter turns indexed by [face seen][face at reference side]
  localparam logic [1:0] ROT_TABLE [6][6] = '{
    '{2'd0, 2'd3, 2'd2, 2'd0, 2'd1, 2'd0},
    '{2'd0, 2'd0, 2'd1, 2'd2, 2'd0, 2'd3},
    '{2'd0, 2'd3, 2'd0, 2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd3, 2'd0, 2'd0, 2'd1, 2'd2},
    '{2'd0, 2'd0, 2'd3, 2'd2, 2'd0, 2'd1},
    '{2'd0, 2'd1, 2'd0, 2'd2, 2'd3, 2'd0}
  };

  // one input item
  typedef struct packed {
    logic   op;
    logic [2:0] move;
    faces_t load;
    face_t  target;
  } cot_item_t;

  // one result item
  typedef struct packed {
    faces_t     faces;
    logic [1:0] front_turn;
    logic [1:0] back_turn;
    logic [1:0] up_turn;
    logic [1:0] down_turn;
    logic [1:0] left_turn;
    logic [1:0] right_turn;
    logic [2:0] target_position;
    logic [2:0] top_sequence;
    logic       error_flag;
  } cot_result_t;

  // rotation lookup, zero for codes outside the face set
  function automatic logic [1:0] rot_of(face_t seen, face_t ref_face);
    logic [1:0] r;
    r = 2'd0;
    if (seen < 3'(NumPos) && ref_face < 3'(NumPos)) begin
      r = ROT_TABLE[seen][ref_face];
    end
    return r;
  endfunction

endpackage

// ----- sv/cot_state.sv -----
module cot_state (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  cot_pkg::cot_item_t item_i,
  output cot_pkg::faces_t   faces_o,
  output logic              err_o
);
  import cot_pkg::*;

  faces_t     state_q;
  faces_t     state_d;
  faces_t     moved;
  faces_t     next_faces;
  logic [5:0] seen;
  logic       labels_ok;
  logic       move_err;
  logic       upd_err;

  // check that the loaded labels are a permutation of the six faces
  always_comb begin
    seen = '0;
    for (int i = 0; i < NumPos; i++) begin
      if (item_i.load[i] < 3'(NumPos)) begin
        seen[item_i.load[i]] = 1'b1;
      end
    end
    labels_ok = &seen;
  end

  // fixed position permutations of each move
  always_comb begin
    moved    = state_q;
    move_err = 1'b0;
    case (item_i.move)
      MOVE_NONE: begin
      end
      MOVE_TUMBLE: begin
        moved[POS_UP]    = state_q[POS_BACK];
        moved[POS_BACK]  = state_q[POS_DOWN];
        moved[POS_DOWN]  = state_q[POS_FRONT];
        moved[POS_FRONT] = state_q[POS_UP];
      end
      MOVE_CW: begin
        moved[POS_RIGHT] = state_q[POS_BACK];
        moved[POS_BACK]  = state_q[POS_LEFT];
        moved[POS_LEFT]  = state_q[POS_FRONT];
        moved[POS_FRONT] = state_q[POS_RIGHT];
      end
      MOVE_ACW: begin
        moved[POS_RIGHT] = state_q[POS_FRONT];
        moved[POS_FRONT] = state_q[POS_LEFT];
        moved[POS_LEFT]  = state_q[POS_BACK];
        moved[POS_BACK]  = state_q[POS_RIGHT];
      end
      MOVE_HALF: begin
        moved[POS_RIGHT] = state_q[POS_LEFT];
        moved[POS_BACK]  = state_q[POS_FRONT];
        moved[POS_LEFT]  = state_q[POS_RIGHT];
        moved[POS_FRONT] = state_q[POS_BACK];
      end
      default: begin
        move_err = 1'b1;
      end
    endcase
  end

  // select load or move, rejected updates keep the state
  always_comb begin
    next_faces = state_q;
    upd_err    = 1'b0;
    if (item_i.op == OP_LOAD) begin
      if (labels_ok) begin
        next_faces = item_i.load;
      end else begin
        upd_err = 1'b1;
      end
    end else begin
      next_faces = moved;
      upd_err    = move_err;
    end
    state_d = en_i ? next_faces : state_q;
  end

  assign faces_o = next_faces;
  assign err_o   = upd_err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RESET_FACES;
    end else begin
      state_q <= state_d;
    end
  end

  // an invalid move leaves the orientation untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && item_i.op == OP_MOVE && item_i.move > MOVE_HALF)
      |=> state_q == $past(state_q))
    else $error("invalid move changed the orientation");

  // an accepted load takes the labels as given
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && item_i.op == OP_LOAD && !err_o) |=> state_q == $past(item_i.load))
    else $error("valid load not stored");

endmodule

// ----- sv/cot_report.sv -----
module cot_report (
  input  cot_pkg::faces_t     faces_i,
  input  cot_pkg::face_t      target_i,
  input  logic                upd_err_i,
  output cot_pkg::cot_result_t res_o
);
  import cot_pkg::*;

  logic       found;
  logic [2:0] tpos;

  // first position holding the requested face
  always_comb begin
    found = 1'b0;
    tpos  = 3'd0;
    for (int i = 0; i < NumPos; i++) begin
      if (!found && faces_i[i] == target_i) begin
        found = 1'b1;
        tpos  = 3'(i);
      end
    end
  end

  // result fields from the updated orientation
  always_comb begin
    res_o.faces           = faces_i;
    res_o.front_turn      = rot_of(faces_i[POS_FRONT], faces_i[POS_UP]);
    res_o.back_turn       = rot_of(faces_i[POS_BACK], faces_i[POS_UP]);
    res_o.up_turn         = rot_of(faces_i[POS_UP], faces_i[POS_BACK]);
    res_o.down_turn       = rot_of(faces_i[POS_DOWN], faces_i[POS_FRONT]);
    res_o.left_turn       = rot_of(faces_i[POS_LEFT], faces_i[POS_UP]);
    res_o.right_turn      = rot_of(faces_i[POS_RIGHT], faces_i[POS_UP]);
    res_o.target_position = tpos;
    // the sequence code matches the position index
    res_o.top_sequence    = tpos;
    res_o.error_flag      = upd_err_i | ~found;
  end

endmodule

// ----- sv/cube_orientation_tracker_core.sv -----
// Cube orientation tracker: keeps the face held at each of six positions.
// Input channel s_axis: one item per handshake; tuser is the operation
// (move or load), tdata carries the move code, six load labels and the
// face to look for. Output channel m_axis: one result per input item with
// the packed orientation, six face turns, target position and top-move
// code in tdata, and the error flag in tuser.
// An item taken sits in the input register, is applied to the orientation
// state and lands in the result register once that register is free or read.
// Throughput: one item per cycle while the receiver keeps m_axis_tready high;
// the orientation update and table lookups are a single level of muxing
// between input and result register.
// Reset puts the orientation back to U R F D L B and empties both
// registers. When the receiver stalls the result register holds, the
// input register can still fill, and s_axis_tready drops once both are
// full; nothing is lost or repeated.
module cube_orientation_tracker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // move[2:0], load_up, load_right, load_front, load_down, load_left,
  // load_back, target_face[23:21]
  input  logic [23:0] s_axis_tdata,
  // operation[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // orientation_word[17:0], front_turn, back_turn, up_turn, down_turn,
  // left_turn, right_turn, target_position, top_sequence[35:33], zeros
  output logic [39:0] m_axis_tdata,
  // error_flag[0]
  output logic [0:0]  m_axis_tuser
);
  import cot_pkg::*;

  logic        s1_valid_q;
  cot_item_t   s1_item_q;
  cot_item_t   in_item;
  logic        s1_adv;
  logic        out_valid_q;
  cot_result_t res_q;
  cot_result_t res_d;
  faces_t      new_faces;
  logic        upd_err;
  logic [5:0]  out_face_mask;

  // unpack the input item
  assign in_item.op     = s_axis_tuser[0];
  assign in_item.move   = s_axis_tdata[2:0];
  assign in_item.load   = s_axis_tdata[20:3];
  assign in_item.target = s_axis_tdata[23:21];

  // pipeline flow control
  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_item_q <= in_item;
    end
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  // orientation state and update
  cot_state u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (s1_adv),
    .item_i  (s1_item_q),
    .faces_o (new_faces),
    .err_o   (upd_err)
  );

  // result fields
  cot_report u_report (
    .faces_i   (new_faces),
    .target_i  (s1_item_q.target),
    .upd_err_i (upd_err),
    .res_o     (res_d)
  );

  // pack the result item
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, res_q.top_sequence, res_q.target_position,
                          res_q.right_turn, res_q.left_turn, res_q.down_turn,
                          res_q.up_turn, res_q.back_turn, res_q.front_turn,
                          res_q.faces};
  assign m_axis_tuser  = res_q.error_flag;

  // set of faces present in the reported orientation
  always_comb begin
    out_face_mask = '0;
    for (int i = 0; i < NumPos; i++) begin
      if (res_q.faces[i] < 3'(NumPos)) begin
        out_face_mask[res_q.faces[i]] = 1'b1;
      end
    end
  end

  // input register empty means the block takes an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> s_axis_tready)
    else $error("input stalled with empty input register");

  // the orientation always stays a permutation of the six faces
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $countones(out_face_mask) == NumPos)
    else $error("reported orientation is not a permutation");

  // a clean result names a real position and its matching sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !res_q.error_flag) |->
      (res_q.target_position < 3'(NumPos) &&
       res_q.top_sequence == res_q.target_position))
    else $error("inconsistent target report");

endmodule

// ----- test/cot_tracker_check_pkg.sv -----
`timescale 1ns / 1ps
package cot_tracker_check_pkg;
  import cot_pkg::*;

  // face codes share the position encoding
  localparam face_t FACE_U = 3'd0;
  localparam face_t FACE_R = 3'd1;
  localparam face_t FACE_F = 3'd2;
  localparam face_t FACE_D = 3'd3;
  localparam face_t FACE_L = 3'd4;
  localparam face_t FACE_B = 3'd5;
  localparam face_t FACE_INVALID_LO = 3'd6;
  localparam face_t FACE_INVALID_HI = 3'd7;

  // move codes with no defined action
  localparam logic [2:0] MOVE_INVALID_LO = 3'd5;
  localparam logic [2:0] MOVE_INVALID_HI = 3'd7;

  class orientation_scoreboard;
    faces_t      held_faces;
    cot_result_t pending_results[$];
    int          mismatches;
    int          items_noted;
    int          loads_noted;
    int          flagged;
    int          results_checked;

    function new();
      int k;
      for (k = 0; k < NumPos; k++) begin
        held_faces[k] = face_t'(k);
      end
      mismatches = 0;
      items_noted = 0;
      loads_noted = 0;
      flagged = 0;
      results_checked = 0;
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction

    // right takes back, back takes left, left takes front, front takes right
    static function faces_t spun_clockwise(faces_t f);
      faces_t n;
      n = f;
      n[POS_RIGHT] = f[POS_BACK];
      n[POS_BACK]  = f[POS_LEFT];
      n[POS_LEFT]  = f[POS_FRONT];
      n[POS_FRONT] = f[POS_RIGHT];
      return n;
    endfunction

    // quarter turns of a seen face against the face at its reference side
    static function logic [1:0] quarter_turns(face_t seen, face_t ref_side);
      logic [11:0] row;
      case (seen)
        FACE_U: row = {2'd0, 2'd1, 2'd0, 2'd2, 2'd3, 2'd0};
        FACE_R: row = {2'd3, 2'd0, 2'd2, 2'd1, 2'd0, 2'd0};
        FACE_F: row = {2'd0, 2'd1, 2'd2, 2'd0, 2'd3, 2'd0};
        FACE_D: row = {2'd2, 2'd1, 2'd0, 2'd0, 2'd3, 2'd0};
        FACE_L: row = {2'd1, 2'd0, 2'd2, 2'd3, 2'd0, 2'd0};
        FACE_B: row = {2'd0, 2'd3, 2'd2, 2'd0, 2'd1, 2'd0};
        default: row = '0;
      endcase
      if (ref_side > FACE_B) begin
        return 2'd0;
      end
      return row[2 * ref_side +: 2];
    endfunction

    // apply one accepted item and queue the result it should produce
    function void note_item(logic op, logic [23:0] data);
      logic [2:0]  move;
      faces_t      labels;
      face_t       target;
      faces_t      prev;
      logic [5:0]  seen_mask;
      logic        bad;
      logic        found;
      cot_result_t r;
      int          k;
      move   = data[2:0];
      labels = data[20:3];
      target = data[23:21];
      bad    = 1'b0;
      items_noted++;
      if (op == OP_LOAD) begin
        loads_noted++;
        seen_mask = '0;
        for (k = 0; k < NumPos; k++) begin
          if (labels[k] <= FACE_B) seen_mask[labels[k]] = 1'b1;
        end
        if (&seen_mask) held_faces = labels;
        else bad = 1'b1;
      end else begin
        prev = held_faces;
        case (move)
          MOVE_NONE: ;
          MOVE_TUMBLE: begin
            held_faces[POS_UP]    = prev[POS_BACK];
            held_faces[POS_BACK]  = prev[POS_DOWN];
            held_faces[POS_DOWN]  = prev[POS_FRONT];
            held_faces[POS_FRONT] = prev[POS_UP];
          end
          MOVE_CW: held_faces = spun_clockwise(prev);
          MOVE_ACW: begin
            held_faces[POS_RIGHT] = prev[POS_FRONT];
            held_faces[POS_FRONT] = prev[POS_LEFT];
            held_faces[POS_LEFT]  = prev[POS_BACK];
            held_faces[POS_BACK]  = prev[POS_RIGHT];
          end
          MOVE_HALF: held_faces = spun_clockwise(spun_clockwise(prev));
          default: bad = 1'b1;
        endcase
      end

      r.faces      = held_faces;
      r.front_turn = quarter_turns(held_faces[POS_FRONT], held_faces[POS_UP]);
      r.back_turn  = quarter_turns(held_faces[POS_BACK], held_faces[POS_UP]);
      r.up_turn    = quarter_turns(held_faces[POS_UP], held_faces[POS_BACK]);
      r.down_turn  = quarter_turns(held_faces[POS_DOWN], held_faces[POS_FRONT]);
      r.left_turn  = quarter_turns(held_faces[POS_LEFT], held_faces[POS_UP]);
      r.right_turn = quarter_turns(held_faces[POS_RIGHT], held_faces[POS_UP]);

      // first position holding the target; the top-move code follows it
      found = 1'b0;
      r.target_position = '0;
      for (k = 0; k < NumPos; k++) begin
        if (!found && held_faces[k] == target) begin
          found = 1'b1;
          r.target_position = 3'(k);
        end
      end
      r.top_sequence = r.target_position;
      r.error_flag   = bad | ~found;
      if (r.error_flag) flagged++;
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("mismatch %0d at %0t ns: %s", mismatches, $time, what);
    endtask

    // compare one accepted result with the oldest queued one
    task check_result(logic [39:0] data, logic [0:0] user);
      cot_result_t got;
      cot_result_t want;
      got.faces           = data[17:0];
      got.front_turn      = data[19:18];
      got.back_turn       = data[21:20];
      got.up_turn         = data[23:22];
      got.down_turn       = data[25:24];
      got.left_turn       = data[27:26];
      got.right_turn      = data[29:28];
      got.target_position = data[32:30];
      got.top_sequence    = data[35:33];
      got.error_flag      = user[0];
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with no item pending", data));
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      if (got.faces !== want.faces)
        report_mismatch($sformatf("orientation %h, want %h", got.faces, want.faces));
      if (got.front_turn !== want.front_turn)
        report_mismatch($sformatf("front turn %0d, want %0d", got.front_turn,
                                  want.front_turn));
      if (got.back_turn !== want.back_turn)
        report_mismatch($sformatf("back turn %0d, want %0d", got.back_turn,
                                  want.back_turn));
      if (got.up_turn !== want.up_turn)
        report_mismatch($sformatf("up turn %0d, want %0d", got.up_turn, want.up_turn));
      if (got.down_turn !== want.down_turn)
        report_mismatch($sformatf("down turn %0d, want %0d", got.down_turn,
                                  want.down_turn));
      if (got.left_turn !== want.left_turn)
        report_mismatch($sformatf("left turn %0d, want %0d", got.left_turn,
                                  want.left_turn));
      if (got.right_turn !== want.right_turn)
        report_mismatch($sformatf("right turn %0d, want %0d", got.right_turn,
                                  want.right_turn));
      if (got.target_position !== want.target_position)
        report_mismatch($sformatf("target position %0d, want %0d",
                                  got.target_position, want.target_position));
      if (got.top_sequence !== want.top_sequence)
        report_mismatch($sformatf("top sequence %0d, want %0d", got.top_sequence,
                                  want.top_sequence));
      if (got.error_flag !== want.error_flag)
        report_mismatch($sformatf("error flag %b, want %b", got.error_flag,
                                  want.error_flag));
    endtask
  endclass

endpackage

// ----- test/cube_orientation_tracker_core_test.sv -----
`timescale 1ns / 1ps
module cube_orientation_tracker_core_test;
  import cot_pkg::*;
  import cot_tracker_check_pkg::*;

  localparam int RandomItems = 1425;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 10;

  // the middle one of the move codes with no defined action
  localparam logic [2:0] MOVE_INVALID_MID = 3'd6;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  orientation_scoreboard tracker_sb;
  int idle_style;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  cube_orientation_tracker_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // wait before the next item: none, fully random, or mostly back to back
  function int draw_wait();
    case (idle_style)
      0: return 0;
      1: return $urandom_range(0, 10);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
    endcase
  endfunction

  function faces_t faces_of(face_t u, face_t r, face_t f, face_t d, face_t l, face_t b);
    return {b, l, d, f, r, u};
  endfunction

  // shuffled set of the six faces
  function faces_t random_arrangement();
    faces_t arr;
    face_t  tmp;
    int     k;
    int     j;
    for (k = 0; k < NumPos; k++) arr[k] = face_t'(k);
    for (k = NumPos - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = arr[k];
      arr[k] = arr[j];
      arr[j] = tmp;
    end
    return arr;
  endfunction

  // present one item and hold it until taken
  task send_item(logic op, logic [2:0] move, faces_t labels, face_t target);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {target, labels, move};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // note accepted items and check results, and watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        tracker_sb.note_item(s_axis_tuser[0], s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        tracker_sb.check_result(m_axis_tdata, m_axis_tuser);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  // result side: random stall, then ready until one item is taken
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    wait (idle_cycles >= StallLimit);
    $display("timeout: no item moved for %0d cycles", StallLimit);
    $display("FAIL");
    $finish;
  end

  initial begin
    int       n;
    int       kind;
    logic     op;
    logic [2:0] move;
    faces_t   labels;
    face_t    target;
    tracker_sb = new();
    idle_cycles = 0;
    idle_style = 1;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_MOVE;
    m_axis_tready <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every move in turn, starting from the reset orientation, load fields ignored
    send_item(OP_MOVE, MOVE_NONE, '1, FACE_U);
    send_item(OP_MOVE, MOVE_TUMBLE, '1, FACE_F);
    send_item(OP_MOVE, MOVE_CW, '0, FACE_R);
    send_item(OP_MOVE, MOVE_ACW, '0, FACE_B);
    send_item(OP_MOVE, MOVE_HALF, '1, FACE_L);
    // invalid moves keep the state; two targets outside the face set
    send_item(OP_MOVE, MOVE_INVALID_LO, '0, FACE_D);
    send_item(OP_MOVE, MOVE_INVALID_MID, '0, FACE_INVALID_LO);
    send_item(OP_MOVE, MOVE_INVALID_HI, '1, FACE_INVALID_HI);
    // load back to reset order, move field ignored
    send_item(OP_LOAD, MOVE_INVALID_HI,
              faces_of(FACE_U, FACE_R, FACE_F, FACE_D, FACE_L, FACE_B), FACE_D);
    // rejected loads: all ones, a duplicate, a label past the face set, all zeros
    send_item(OP_LOAD, MOVE_NONE, '1, FACE_B);
    send_item(OP_LOAD, MOVE_CW,
              faces_of(FACE_U, FACE_U, FACE_R, FACE_F, FACE_D, FACE_L), FACE_R);
    send_item(OP_LOAD, MOVE_NONE,
              faces_of(FACE_INVALID_LO, FACE_R, FACE_F, FACE_D, FACE_L, FACE_B),
              FACE_U);
    send_item(OP_LOAD, MOVE_NONE, '0, FACE_U);
    // mirror image and faces beside their opposites
    send_item(OP_LOAD, MOVE_NONE,
              faces_of(FACE_U, FACE_L, FACE_F, FACE_D, FACE_R, FACE_B), FACE_R);
    send_item(OP_LOAD, MOVE_TUMBLE,
              faces_of(FACE_U, FACE_R, FACE_D, FACE_F, FACE_L, FACE_B), FACE_F);
    send_item(OP_LOAD, MOVE_NONE,
              faces_of(FACE_B, FACE_L, FACE_D, FACE_F, FACE_R, FACE_U), FACE_U);
    send_item(OP_MOVE, MOVE_TUMBLE, '1, FACE_INVALID_LO);
    send_item(OP_MOVE, MOVE_CW, '0, FACE_B);
    send_item(OP_MOVE, MOVE_ACW, '1, FACE_L);
    send_item(OP_MOVE, MOVE_HALF, '0, FACE_INVALID_HI);
    send_item(OP_LOAD, MOVE_NONE,
              faces_of(FACE_U, FACE_R, FACE_F, FACE_D, FACE_L, FACE_B), FACE_U);

    // random part: mostly valid moves and proper loads, some noise
    for (n = 0; n < RandomItems; n++) begin
      if (n % 180 == 0) idle_style = $urandom_range(0, 2);
      kind = $urandom_range(0, 99);
      labels = faces_t'($urandom);
      move = 3'($urandom);
      if (kind < 68) begin
        op = OP_MOVE;
        move = 3'($urandom_range(MOVE_NONE, MOVE_HALF));
      end else if (kind < 74) begin
        op = OP_MOVE;
        move = 3'($urandom_range(MOVE_INVALID_LO, MOVE_INVALID_HI));
      end else if (kind < 90) begin
        op = OP_LOAD;
        labels = random_arrangement();
      end else begin
        op = OP_LOAD;
      end
      if ($urandom_range(0, 15) == 0)
        target = face_t'($urandom_range(FACE_INVALID_LO, FACE_INVALID_HI));
      else
        target = face_t'($urandom_range(FACE_U, FACE_B));
      send_item(op, move, labels, target);
    end
    s_axis_tvalid <= 1'b0;

    // drain, then give any stray result time to show up
    while (tracker_sb.pending_count() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("tracker run: %0d items sent, %0d of them loads, %0d flagged as errors",
             tracker_sb.items_noted, tracker_sb.loads_noted, tracker_sb.flagged);
    $display("tracker run: %0d results checked, %0d mismatches",
             tracker_sb.results_checked, tracker_sb.mismatches);
    if (tracker_sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/cot_pkg.sv
sv/cot_state.sv
sv/cot_report.sv
sv/cube_orientation_tracker_core.sv
test/cot_tracker_check_pkg.sv
test/cube_orientation_tracker_core_test.sv
